// ===== hdl/water_sensor_conditioner_top_assert.svh =====
// ============================================================================
// Water sensor conditioner assertion macros
// Shared property wrappers for the checker attached to the top level.
// ============================================================================
`ifndef WATER_SENSOR_CONDITIONER_TOP_ASSERT_SVH
`define WATER_SENSOR_CONDITIONER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clock and disabled during reset.
`define WSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock and disabled during reset.
`define WSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/wsc_pkg.sv =====
// ============================================================================
// Water sensor conditioner package
// Types and fixed constants shared by the conditioner and its checker.
// ============================================================================
package wsc_pkg;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP,
      ST_MUL,
      ST_POST,
      ST_DONE
   } state_type;

   // Configuration register indexes.
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_READ_INTERVAL = 3'd0;
   localparam csr_index_type CSR_PH_OFFSET     = 3'd1;
   localparam csr_index_type CSR_PH_SCALE      = 3'd2;
   localparam csr_index_type CSR_TEMP_OFFSET   = 3'd3;
   localparam csr_index_type CSR_TEMP_SCALE    = 3'd4;
   localparam csr_index_type CSR_ORP_OFFSET    = 3'd5;
   localparam csr_index_type CSR_ORP_SCALE     = 3'd6;

   // Channel lanes.
   localparam int LANES   = 3;
   localparam int LANE_PH = 0;
   localparam int LANE_TP = 1;
   localparam int LANE_OR = 2;

   // Step counter for the serial divider and multiplier.
   typedef logic [4:0] count_type;
   localparam int        DIV_STEPS = 12;
   localparam int        MUL_STEPS = 17;
   localparam count_type DIV_LAST  = count_type'(DIV_STEPS - 1);
   localparam count_type MUL_LAST  = count_type'(MUL_STEPS - 1);

   // Code to millivolts: code * 3300 / 4095 reduces to code * 220 / 273.
   localparam int MV_GAIN    = 220;
   localparam int MV_DIVISOR = 273;

   // Limits in milli-units.
   localparam int PH_MAX_MILLI  = 14000;
   localparam int TEMP_MIN      = -10000;
   localparam int TEMP_MAX      = 50000;
   localparam int ORP_MIN       = -1000;
   localparam int ORP_MAX       = 1000;
   localparam int CL_ZERO_MV    = 650;
   localparam int CL_FULL_MV    = 1150;
   localparam int CL_MAX_MILLI  = 10000;
   localparam int PH_STILL      = 10;
   localparam int TEMP_STILL    = 100;
   localparam int STUCK_LIMIT   = 10;
   localparam int PREVIOUS_INIT = -1000;

   // Reset values of the configuration registers.
   localparam logic [31:0]        INTERVAL_INIT = 32'd1000;
   localparam logic signed [23:0] SCALE_INIT    = 24'sd65536;

   // Per-cycle control decoded from the sequencer state.
   typedef struct packed {
      logic accept;
      logic div_step;
      logic div_last;
      logic mul_load;
      logic mul_step;
      logic mul_last;
      logic post;
      logic emit;
   } ctl_type;

endpackage

// ===== hdl/water_sensor_conditioner_top.sv =====
// ============================================================================
// Water sensor conditioner
// Converts three ADC codes to calibrated pH, temperature, ORP and chlorine,
// caches range-checked readings and flags a stuck sensor set.
// ============================================================================
//
//   Channel  Direction  Handshake              Word contents
//   req_     in         req_valid / req_ready  time stamp and three ADC codes
//   rsp_     out        rsp_valid / rsp_ready  readings, stamp, fresh, stuck
//   csr_     in         csr_valid / csr_ready  register index and data
//
// A word whose read interval has elapsed passes from acceptance through the
// bit-serial code divider, a load step, the bit-serial calibration multiplier,
// a post-processing and an output step before the next word can be accepted.
// The three channels run in parallel lanes. A word inside the interval goes
// straight to post-processing and output. Reset is synchronous and restores
// the register defaults and the cached set. The result waits in an output
// register; a stalled rsp_ready holds the block in its output step.
//
module water_sensor_conditioner_top
   import wsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_time_ms,
   input  logic [11:0]        req_ph_code,
   input  logic [11:0]        req_temp_code,
   input  logic [11:0]        req_orp_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [13:0]        rsp_ph_milli,
   output logic signed [16:0] rsp_temp_milli,
   output logic signed [10:0] rsp_orp_mv,
   output logic [13:0]        rsp_chlorine_milli,
   output logic [31:0]        rsp_stamp_ms,
   output logic               rsp_fresh,
   output logic               rsp_stuck,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   // Configuration registers.
   logic [31:0]        interval_ff, interval_in;
   logic signed [15:0] offset_ff [LANES];
   logic signed [15:0] offset_in [LANES];
   logic signed [23:0] scale_ff  [LANES];
   logic signed [23:0] scale_in  [LANES];

   // Sequencer.
   state_type state_ff, state_in;
   count_type cnt_ff, cnt_in;
   ctl_type   ctl;

   // Word in flight.
   logic [31:0] time_ff, time_in;
   logic        took_read_ff, took_read_in;
   logic        fresh_ff, fresh_in;
   logic [11:0] req_code [LANES];
   logic signed [25:0] cal_w [LANES];
   logic        elapsed;

   // Cached set and stuck detector state.
   logic [31:0]        last_read_ff, last_read_in;
   logic [13:0]        cached_ph_ff, cached_ph_in;
   logic signed [16:0] cached_temp_ff, cached_temp_in;
   logic signed [10:0] cached_orp_ff, cached_orp_in;
   logic [13:0]        cached_cl_ff, cached_cl_in;
   logic [31:0]        cached_stamp_ff, cached_stamp_in;
   logic signed [14:0] prev_ph_ff, prev_ph_in;
   logic signed [16:0] prev_temp_ff, prev_temp_in;
   logic [7:0]         count_ff, count_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [13:0]        rsp_ph_ff, rsp_ph_in;
   logic signed [16:0] rsp_temp_ff, rsp_temp_in;
   logic signed [10:0] rsp_orp_ff, rsp_orp_in;
   logic [13:0]        rsp_cl_ff, rsp_cl_in;
   logic [31:0]        rsp_stamp_ff, rsp_stamp_in;
   logic               rsp_fresh_ff, rsp_fresh_in;
   logic               rsp_stuck_ff, rsp_stuck_in;

   // Post-processing terms.
   logic signed [25:0] ph_cal, tp_cal, or_cal;
   logic [13:0]        ph_val, cl_val;
   logic [25:0]        orp_rel;
   logic [8:0]         cl_off;
   logic               temp_ok, orp_ok;

   // Stuck detector terms.
   logic signed [15:0] ph_delta;
   logic signed [17:0] temp_delta;
   logic               unchanged, stuck_now;
   logic [7:0]         count_next;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   assign req_code[LANE_PH] = req_ph_code;
   assign req_code[LANE_TP] = req_temp_code;
   assign req_code[LANE_OR] = req_orp_code;

   // Read interval check on the wrapping millisecond clock.
   assign elapsed = (req_time_ms - last_read_ff) >= interval_ff;

   // Configuration writes.
   always_comb begin
      interval_in = interval_ff;
      offset_in   = offset_ff;
      scale_in    = scale_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_READ_INTERVAL: interval_in         = csr_data;
            CSR_PH_OFFSET:     offset_in[LANE_PH]  = csr_data[15:0];
            CSR_PH_SCALE:      scale_in[LANE_PH]   = csr_data[23:0];
            CSR_TEMP_OFFSET:   offset_in[LANE_TP]  = csr_data[15:0];
            CSR_TEMP_SCALE:    scale_in[LANE_TP]   = csr_data[23:0];
            CSR_ORP_OFFSET:    offset_in[LANE_OR]  = csr_data[15:0];
            CSR_ORP_SCALE:     scale_in[LANE_OR]   = csr_data[23:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = elapsed ? ST_DIV : ST_POST;
            end
         end
         ST_DIV: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_MUL;
         ST_MUL: begin
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_POST;
            end
         end
         ST_POST: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control decode.
   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE: ctl.accept = req_valid;
         ST_DIV: begin
            ctl.div_step = 1'b1;
            ctl.div_last = (cnt_ff == DIV_LAST);
         end
         ST_PREP: ctl.mul_load = 1'b1;
         ST_MUL: begin
            ctl.mul_step = 1'b1;
            ctl.mul_last = (cnt_ff == MUL_LAST);
         end
         ST_POST: ctl.post = 1'b1;
         ST_DONE: ctl.emit = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Step counter shared by the divider and multiplier phases.
   always_comb begin
      if ((ctl.div_step && !ctl.div_last) || (ctl.mul_step && !ctl.mul_last)) begin
         cnt_in = cnt_ff + count_type'(1);
      end else begin
         cnt_in = '0;
      end
   end

   // One lane per channel: serial divider to millivolts, then serial multiply.
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [8:0]         rem_ff, rem_in;
      logic [11:0]        dq_ff, dq_in;
      logic signed [24:0] hi_ff, hi_in;
      logic [16:0]        lo_ff, lo_in;
      logic [19:0]        dividend;
      logic [9:0]         trial;
      logic               trial_ge;
      logic signed [16:0] diff;
      logic signed [25:0] scale_ext, addend, sum;

      always_comb begin
         dividend  = 20'(req_code[g]) * 20'(MV_GAIN);
         trial     = {rem_ff, dq_ff[11]};
         trial_ge  = trial >= 10'(MV_DIVISOR);
         diff      = {5'b0, dq_ff} - {offset_ff[g][15], offset_ff[g]};
         scale_ext = {{2{scale_ff[g][23]}}, scale_ff[g]};
         // The sign bit of the multiplier carries negative weight.
         if (!lo_ff[0]) begin
            addend = '0;
         end else if (ctl.mul_last) begin
            addend = -scale_ext;
         end else begin
            addend = scale_ext;
         end
         sum = {hi_ff[24], hi_ff} + addend;

         rem_in = rem_ff;
         dq_in  = dq_ff;
         if (ctl.accept) begin
            rem_in = {1'b0, dividend[19:12]};
            dq_in  = dividend[11:0];
         end else if (ctl.div_step) begin
            rem_in = trial_ge ? 9'(trial - 10'(MV_DIVISOR)) : trial[8:0];
            dq_in  = {dq_ff[10:0], trial_ge};
         end

         hi_in = hi_ff;
         lo_in = lo_ff;
         if (ctl.mul_load) begin
            hi_in = '0;
            lo_in = diff;
         end else if (ctl.mul_step) begin
            hi_in = sum[25:1];
            lo_in = {sum[0], lo_ff[16:1]};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
      end

      // Product shifted down by 16 bits, floored.
      assign cal_w[g] = {hi_ff, lo_ff[16]};
   end

   // Clamps and range checks on the calibrated values.
   always_comb begin
      ph_cal = cal_w[LANE_PH];
      tp_cal = cal_w[LANE_TP];
      or_cal = cal_w[LANE_OR];

      if (ph_cal < 0) begin
         ph_val = '0;
      end else if (ph_cal > PH_MAX_MILLI) begin
         ph_val = 14'(PH_MAX_MILLI);
      end else begin
         ph_val = ph_cal[13:0];
      end

      temp_ok = (tp_cal >= TEMP_MIN) && (tp_cal <= TEMP_MAX);
      orp_ok  = (or_cal >= ORP_MIN) && (or_cal <= ORP_MAX);

      // Chlorine is twenty milli-ppm per millivolt above the zero point.
      orp_rel = or_cal - 26'(CL_ZERO_MV);
      cl_off  = orp_rel[8:0];
      if (or_cal <= CL_ZERO_MV) begin
         cl_val = '0;
      end else if (or_cal >= CL_FULL_MV) begin
         cl_val = 14'(CL_MAX_MILLI);
      end else begin
         cl_val = ({5'b0, cl_off} << 4) + ({5'b0, cl_off} << 2);
      end
   end

   // Stuck detector on the cached set.
   always_comb begin
      ph_delta   = {2'b0, cached_ph_ff} - {prev_ph_ff[14], prev_ph_ff};
      temp_delta = {cached_temp_ff[16], cached_temp_ff} - {prev_temp_ff[16], prev_temp_ff};
      unchanged  = (ph_delta > -PH_STILL) && (ph_delta < PH_STILL) &&
                   (temp_delta > -TEMP_STILL) && (temp_delta < TEMP_STILL);
      if (!unchanged) begin
         count_next = '0;
      end else if (count_ff != 8'hFF) begin
         count_next = count_ff + 8'd1;
      end else begin
         count_next = count_ff;
      end
      stuck_now = unchanged && (count_next > 8'(STUCK_LIMIT));
   end

   // Word, cache and output register updates.
   always_comb begin
      time_in         = time_ff;
      took_read_in    = took_read_ff;
      fresh_in        = fresh_ff;
      last_read_in    = last_read_ff;
      cached_ph_in    = cached_ph_ff;
      cached_temp_in  = cached_temp_ff;
      cached_orp_in   = cached_orp_ff;
      cached_cl_in    = cached_cl_ff;
      cached_stamp_in = cached_stamp_ff;
      prev_ph_in      = prev_ph_ff;
      prev_temp_in    = prev_temp_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_ph_in       = rsp_ph_ff;
      rsp_temp_in     = rsp_temp_ff;
      rsp_orp_in      = rsp_orp_ff;
      rsp_cl_in       = rsp_cl_ff;
      rsp_stamp_in    = rsp_stamp_ff;
      rsp_fresh_in    = rsp_fresh_ff;
      rsp_stuck_in    = rsp_stuck_ff;

      if (ctl.accept) begin
         time_in      = req_time_ms;
         took_read_in = elapsed;
      end

      if (ctl.post) begin
         fresh_in = took_read_ff && temp_ok && orp_ok;
         if (took_read_ff && temp_ok && orp_ok) begin
            cached_ph_in    = ph_val;
            cached_temp_in  = tp_cal[16:0];
            cached_orp_in   = or_cal[10:0];
            cached_cl_in    = cl_val;
            cached_stamp_in = time_ff;
            last_read_in    = time_ff;
         end
      end

      if (ctl.emit) begin
         count_in = count_next;
         if (!stuck_now) begin
            prev_ph_in   = {1'b0, cached_ph_ff};
            prev_temp_in = cached_temp_ff;
         end
         rsp_valid_in = 1'b1;
         rsp_ph_in    = cached_ph_ff;
         rsp_temp_in  = cached_temp_ff;
         rsp_orp_in   = cached_orp_ff;
         rsp_cl_in    = cached_cl_ff;
         rsp_stamp_in = cached_stamp_ff;
         rsp_fresh_in = fresh_ff;
         rsp_stuck_in = stuck_now;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff     <= INTERVAL_INIT;
         offset_ff       <= '{default: '0};
         scale_ff        <= '{default: SCALE_INIT};
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         last_read_ff    <= '0;
         cached_ph_ff    <= '0;
         cached_temp_ff  <= '0;
         cached_orp_ff   <= '0;
         cached_cl_ff    <= '0;
         cached_stamp_ff <= '0;
         prev_ph_ff      <= 15'(PREVIOUS_INIT);
         prev_temp_ff    <= 17'(PREVIOUS_INIT);
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         interval_ff     <= interval_in;
         offset_ff       <= offset_in;
         scale_ff        <= scale_in;
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         last_read_ff    <= last_read_in;
         cached_ph_ff    <= cached_ph_in;
         cached_temp_ff  <= cached_temp_in;
         cached_orp_ff   <= cached_orp_in;
         cached_cl_ff    <= cached_cl_in;
         cached_stamp_ff <= cached_stamp_in;
         prev_ph_ff      <= prev_ph_in;
         prev_temp_ff    <= prev_temp_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      time_ff      <= time_in;
      took_read_ff <= took_read_in;
      fresh_ff     <= fresh_in;
      rsp_ph_ff    <= rsp_ph_in;
      rsp_temp_ff  <= rsp_temp_in;
      rsp_orp_ff   <= rsp_orp_in;
      rsp_cl_ff    <= rsp_cl_in;
      rsp_stamp_ff <= rsp_stamp_in;
      rsp_fresh_ff <= rsp_fresh_in;
      rsp_stuck_ff <= rsp_stuck_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ph_milli       = rsp_ph_ff;
   assign rsp_temp_milli     = rsp_temp_ff;
   assign rsp_orp_mv         = rsp_orp_ff;
   assign rsp_chlorine_milli = rsp_cl_ff;
   assign rsp_stamp_ms       = rsp_stamp_ff;
   assign rsp_fresh          = rsp_fresh_ff;
   assign rsp_stuck          = rsp_stuck_ff;

endmodule

// ===== hdl/wsc_checker.sv =====
// ============================================================================
// Water sensor conditioner checker
// Port-level checks on the conditioner, attached to the top level by bind.
// ============================================================================
`include "water_sensor_conditioner_top_assert.svh"

module wsc_checker
   import wsc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [31:0]        req_time_ms,
   input logic [11:0]        req_ph_code,
   input logic [11:0]        req_temp_code,
   input logic [11:0]        req_orp_code,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [13:0]        rsp_ph_milli,
   input logic signed [16:0] rsp_temp_milli,
   input logic signed [10:0] rsp_orp_mv,
   input logic [13:0]        rsp_chlorine_milli,
   input logic [31:0]        rsp_stamp_ms,
   input logic               rsp_fresh,
   input logic               rsp_stuck,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [2:0]         csr_index,
   input logic [31:0]        csr_data
);

   // A stalled result word stays valid and holds its stamp, pH and stuck flag.
   `WSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_stamp_ms) && $stable(rsp_ph_milli) && $stable(rsp_stuck), "result word changed while stalled")

   // The block works on one word at a time.
   `WSC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request accepted while a word is in flight")

   // pH and chlorine stay inside their clamps.
   `WSC_ASSERT_NOW(a_clamp_range, rsp_valid, rsp_ph_milli <= PH_MAX_MILLI && rsp_chlorine_milli <= CL_MAX_MILLI, "pH or chlorine outside clamp")

   // Only range-checked temperature and ORP ever reach the output.
   `WSC_ASSERT_NOW(a_check_range, rsp_valid, rsp_temp_milli >= TEMP_MIN && rsp_temp_milli <= TEMP_MAX && rsp_orp_mv >= ORP_MIN && rsp_orp_mv <= ORP_MAX, "temperature or ORP outside range")

endmodule

bind water_sensor_conditioner_top wsc_checker u_wsc_checker (.*);
